### sv/ppw_pkg.sv
// Shared types, constants and helpers for the point projection pipeline.
package ppw_pkg;

  localparam int PPW_FRAC_BITS = 16;

  // request modes
  localparam logic [1:0] MODE_EYE_WR  = 2'd0;
  localparam logic [1:0] MODE_PROJ_WR = 2'd1;
  localparam logic [1:0] MODE_POINT   = 2'd2;

  // configuration register indexes
  localparam logic [3:0] CFG_VP_X = 4'd0;
  localparam logic [3:0] CFG_VP_Y = 4'd1;
  localparam logic [3:0] CFG_VP_W = 4'd2;
  localparam logic [3:0] CFG_VP_H = 4'd3;

  localparam logic [15:0] VP_X_RST = 16'd0;
  localparam logic [15:0] VP_Y_RST = 16'd0;
  localparam logic [14:0] VP_W_RST = 15'd640;
  localparam logic [14:0] VP_H_RST = 15'd480;

  localparam logic signed [63:0] S32_MAX = 64'sd2147483647;
  localparam logic signed [63:0] S32_MIN = -64'sd2147483648;

  // sideband that travels with a request through the transform stages
  typedef struct packed {
    logic               pt;   // point projection, gives a result
    logic               wr;   // projection matrix write
    logic [3:0]         idx;
    logic signed [31:0] val;
    logic signed [31:0] aux;  // eye z once known
  } ppw_side_t;

  // flags past the transform stages
  typedef struct packed {
    logic pt;
    logic wz;   // clip w is zero
  } ppw_flags_t;

  typedef struct packed {
    logic               status;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } ppw_res_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > S32_MAX) r = 32'sh7fffffff;
    else if (v < S32_MIN) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### sv/ppw_xform.sv
// Matrix times vector with per-row bias: product stage, then round, sum and saturate.
module ppw_xform import ppw_pkg::*; #(
  parameter int ROWS      = 4,
  parameter int COLS      = 3,
  parameter int FRAC_BITS = PPW_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ppw_side_t          side_i,
  input  logic signed [31:0] mat_i  [ROWS][COLS],
  input  logic signed [31:0] vec_i  [COLS],
  input  logic signed [31:0] bias_i [ROWS],
  output logic               valid_o,
  output ppw_side_t          side_o,
  output logic signed [31:0] vec_o  [ROWS]
);

  localparam logic signed [63:0] Half = 64'sd1 <<< (FRAC_BITS - 1);

  logic               valid1_q;
  ppw_side_t          side1_q;
  logic signed [63:0] prod_q [ROWS][COLS];
  logic signed [31:0] bias_q [ROWS];
  logic signed [63:0] prod_d [ROWS][COLS];
  logic signed [31:0] vec_d  [ROWS];
  logic signed [31:0] vec_q  [ROWS];
  logic               valid2_q;
  ppw_side_t          side2_q;

  always_comb begin
    for (int r = 0; r < ROWS; r++) begin
      for (int c = 0; c < COLS; c++) begin
        prod_d[r][c] = 64'(mat_i[r][c]) * 64'(vec_i[c]);
      end
    end
  end

  always_comb begin
    logic signed [63:0] acc;
    for (int r = 0; r < ROWS; r++) begin
      acc = 64'(bias_q[r]);
      for (int c = 0; c < COLS; c++) begin
        acc = acc + ((prod_q[r][c] + Half) >>> FRAC_BITS);
      end
      vec_d[r] = sat32(acc);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side1_q <= side_i;
      prod_q  <= prod_d;
      bias_q  <= bias_i;
      side2_q <= side1_q;
      vec_q   <= vec_d;
    end
  end

  assign valid_o = valid2_q;
  assign side_o  = side2_q;
  assign vec_o   = vec_q;

endmodule

### sv/ppw_div.sv
// Three-lane pipelined restoring divider: (num << FRAC_BITS) / den, truncated, saturated.
module ppw_div import ppw_pkg::*; #(
  parameter int FRAC_BITS = PPW_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ppw_flags_t         flags_i,
  input  logic signed [31:0] num_i [3],
  input  logic signed [32:0] den_i,
  output logic               valid_o,
  output ppw_flags_t         flags_o,
  output logic signed [31:0] quo_o [3]
);

  localparam int NW    = 32 + FRAC_BITS;
  localparam int LANES = 3;

  logic               valid_q [NW+1];
  ppw_flags_t         flags_q [NW+1];
  logic [31:0]        den_q   [NW+1];
  logic [LANES-1:0]   neg_q   [NW+1];
  logic [31:0]        rem_q   [NW+1][LANES];
  logic [NW-1:0]      nq_q    [NW+1][LANES];

  logic               valid_f_q;
  ppw_flags_t         flags_f_q;
  logic signed [31:0] quo_q [LANES];

  // operand prep
  logic [32:0] den_mag;
  assign den_mag = den_i[32] ? 33'(-den_i) : den_i;

  always_ff @(posedge clk_i) begin
    logic [32:0] m;
    if (en_i) begin
      flags_q[0] <= flags_i;
      den_q[0]   <= den_mag[31:0];
      for (int l = 0; l < LANES; l++) begin
        m = num_i[l][31] ? 33'(-$signed({num_i[l][31], num_i[l]})) : {1'b0, num_i[l]};
        nq_q[0][l]  <= {m[31:0], {FRAC_BITS{1'b0}}};
        rem_q[0][l] <= '0;
        neg_q[0][l] <= num_i[l][31] ^ den_i[32];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q[0] <= 1'b0;
    else if (en_i) valid_q[0] <= valid_i;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < NW; k++) begin : g_step
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) valid_q[k+1] <= 1'b0;
      else if (en_i) valid_q[k+1] <= valid_q[k];
    end

    always_ff @(posedge clk_i) begin
      logic [32:0] rs;
      logic        ge;
      logic [32:0] diff;
      if (en_i) begin
        flags_q[k+1] <= flags_q[k];
        den_q[k+1]   <= den_q[k];
        neg_q[k+1]   <= neg_q[k];
        for (int l = 0; l < LANES; l++) begin
          rs   = {rem_q[k][l], nq_q[k][l][NW-1]};
          ge   = rs >= {1'b0, den_q[k]};
          diff = rs - {1'b0, den_q[k]};
          rem_q[k+1][l] <= ge ? diff[31:0] : rs[31:0];
          nq_q[k+1][l]  <= {nq_q[k][l][NW-2:0], ge};
        end
      end
    end
  end

  // sign and saturate
  always_ff @(posedge clk_i) begin
    logic [NW-1:0] q;
    logic          big;
    if (en_i) begin
      flags_f_q <= flags_q[NW];
      for (int l = 0; l < LANES; l++) begin
        q   = nq_q[NW][l];
        big = |q[NW-1:31];
        if (neg_q[NW][l]) begin
          if (big && (q != (NW'(1) << 31))) quo_q[l] <= 32'sh80000000;
          else quo_q[l] <= -$signed(q[31:0]);
        end else begin
          quo_q[l] <= big ? 32'sh7fffffff : $signed(q[31:0]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_f_q <= 1'b0;
    else if (en_i) valid_f_q <= valid_q[NW];
  end

  assign valid_o = valid_f_q;
  assign flags_o = flags_f_q;
  assign quo_o   = quo_q;

endmodule

### sv/ppw_vp.sv
// Viewport mapping: scale stage, then halve, offset and saturate.
module ppw_vp import ppw_pkg::*; #(
  parameter int FRAC_BITS = PPW_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  ppw_flags_t         flags_i,
  input  logic signed [31:0] ndc_i [3],
  input  logic [15:0]        vp_x_i,
  input  logic [15:0]        vp_y_i,
  input  logic [14:0]        vp_w_i,
  input  logic [14:0]        vp_h_i,
  output logic               valid_o,
  output ppw_res_t           res_o
);

  localparam logic signed [32:0] One = 33'sd1 <<< FRAC_BITS;

  logic               valid1_q;
  ppw_flags_t         flags1_q;
  logic signed [48:0] tx_q, ty_q;
  logic signed [31:0] z_q;
  logic               valid2_q;
  ppw_res_t           res_q;

  logic signed [32:0] ax, ay, az;
  assign ax = 33'(ndc_i[0]) + One;
  assign ay = 33'(ndc_i[1]) + One;
  assign az = (33'(ndc_i[2]) + One + 33'sd1) >>> 1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else if (en_i) begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q && flags1_q.pt;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [49:0] sx, sy;
    if (en_i) begin
      flags1_q <= flags_i;
      tx_q     <= 49'(ax) * 49'($signed({1'b0, vp_w_i}));
      ty_q     <= 49'(ay) * 49'($signed({1'b0, vp_h_i}));
      z_q      <= az[31:0];
      sx = 50'((tx_q + 49'sd1) >>> 1) + $signed(50'({vp_x_i, {FRAC_BITS{1'b0}}}));
      sy = 50'((ty_q + 49'sd1) >>> 1) + $signed(50'({vp_y_i, {FRAC_BITS{1'b0}}}));
      res_q.status <= flags1_q.wz;
      res_q.x      <= flags1_q.wz ? '0 : sat32(64'(sx));
      res_q.y      <= flags1_q.wz ? '0 : sat32(64'(sy));
      res_q.z      <= flags1_q.wz ? '0 : z_q;
    end
  end

  assign valid_o = valid2_q;
  assign res_o   = res_q;

endmodule

### sv/project_point_to_window_core.sv
// Requests pass the modelview, projection, divider and viewport stages to the output register (Q16.16 by default).
// Throughput: one request per cycle unless stalled; the divider takes one quotient bit per stage.
// Matrix writes take effect in request order and give no result.
// Output register plus one skid entry; the pipeline stalls only when the skid is full.
// Reset clears both matrices, sets the viewport to 0,0 640x480 and empties the pipeline.
module project_point_to_window_core import ppw_pkg::*; #(
  parameter int FRAC_BITS = PPW_FRAC_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] obj_x_i,
  input  logic signed [31:0] obj_y_i,
  input  logic signed [31:0] obj_z_i,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [3:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic               status_o,
  output logic signed [31:0] win_x_o,
  output logic signed [31:0] win_y_o,
  output logic signed [31:0] win_z_o
);

  logic               adv;
  logic               acc;
  logic               out_valid_q;
  logic               skid_q;
  logic signed [31:0] eye_q  [16];
  logic signed [31:0] proj_q [12];
  logic [15:0]        vp_x_q, vp_y_q;
  logic [14:0]        vp_w_q, vp_h_q;

  assign adv         = !skid_q;
  assign in_ready_o  = adv;
  assign acc         = in_valid_i && adv;
  assign cfg_ready_o = 1'b1;

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_x_q <= VP_X_RST;
      vp_y_q <= VP_Y_RST;
      vp_w_q <= VP_W_RST;
      vp_h_q <= VP_H_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_VP_X: vp_x_q <= cfg_data_i;
        CFG_VP_Y: vp_y_q <= cfg_data_i;
        CFG_VP_W: vp_w_q <= cfg_data_i[14:0];
        CFG_VP_H: vp_h_q <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // modelview stage
  ppw_side_t          in_side;
  logic signed [31:0] mv_mat  [4][3];
  logic signed [31:0] mv_vec  [3];
  logic signed [31:0] mv_bias [4];
  logic               mv_valid;
  ppw_side_t          mv_side;
  logic signed [31:0] eye_v   [4];

  always_comb begin
    in_side.pt  = mode_i == MODE_POINT;
    in_side.wr  = mode_i == MODE_PROJ_WR;
    in_side.idx = element_index_i;
    in_side.val = element_value_i;
    in_side.aux = '0;
    mv_vec[0] = obj_x_i;
    mv_vec[1] = obj_y_i;
    mv_vec[2] = obj_z_i;
    for (int r = 0; r < 4; r++) begin
      for (int c = 0; c < 3; c++) mv_mat[r][c] = eye_q[c*4 + r];
      mv_bias[r] = eye_q[12 + r];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 16; i++) eye_q[i] <= '0;
    end else if (acc && mode_i == MODE_EYE_WR) begin
      eye_q[element_index_i] <= element_value_i;
    end
  end

  ppw_xform #(.ROWS(4), .COLS(3), .FRAC_BITS(FRAC_BITS)) u_mv (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(acc), .side_i(in_side),
    .mat_i(mv_mat), .vec_i(mv_vec), .bias_i(mv_bias),
    .valid_o(mv_valid), .side_o(mv_side), .vec_o(eye_v)
  );

  // projection stage; its matrix writes land here to keep request order
  ppw_side_t          pj_side_in;
  logic signed [31:0] pj_mat  [3][4];
  logic signed [31:0] pj_bias [3];
  logic               pj_valid;
  ppw_side_t          pj_side;
  logic signed [31:0] clip_v  [3];
  logic [3:0]         pidx;

  always_comb begin
    pj_side_in     = mv_side;
    pj_side_in.aux = eye_v[2];
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 4; c++) pj_mat[r][c] = proj_q[c*3 + r];
      pj_bias[r] = '0;
    end
    pidx = 4'({2'b00, mv_side.idx[3:2]} * 4'd3) + {2'b00, mv_side.idx[1:0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 12; i++) proj_q[i] <= '0;
    end else if (adv && mv_valid && mv_side.wr && mv_side.idx[1:0] != 2'd3) begin
      proj_q[pidx] <= mv_side.val;
    end
  end

  ppw_xform #(.ROWS(3), .COLS(4), .FRAC_BITS(FRAC_BITS)) u_pj (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(mv_valid), .side_i(pj_side_in),
    .mat_i(pj_mat), .vec_i(eye_v), .bias_i(pj_bias),
    .valid_o(pj_valid), .side_o(pj_side), .vec_o(clip_v)
  );

  // perspective divide, w = -eye z
  ppw_flags_t         dv_flags_in;
  logic signed [32:0] w_v;
  logic               dv_valid;
  ppw_flags_t         dv_flags;
  logic signed [31:0] ndc_v [3];

  assign w_v            = -33'(pj_side.aux);
  assign dv_flags_in.pt = pj_side.pt;
  assign dv_flags_in.wz = pj_side.aux == '0;

  ppw_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(pj_valid), .flags_i(dv_flags_in),
    .num_i(clip_v), .den_i(w_v),
    .valid_o(dv_valid), .flags_o(dv_flags), .quo_o(ndc_v)
  );

  logic     vp_valid;
  ppw_res_t vp_res;

  ppw_vp #(.FRAC_BITS(FRAC_BITS)) u_vp (
    .clk_i, .rst_ni, .en_i(adv), .valid_i(dv_valid), .flags_i(dv_flags),
    .ndc_i(ndc_v), .vp_x_i(vp_x_q), .vp_y_i(vp_y_q), .vp_w_i(vp_w_q), .vp_h_i(vp_h_q),
    .valid_o(vp_valid), .res_o(vp_res)
  );

  // output register and skid entry
  ppw_res_t out_q, skid_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      skid_q      <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= skid_q || vp_valid;
      skid_q      <= 1'b0;
    end else if (vp_valid && !skid_q) begin
      skid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      out_q <= skid_q ? skid_res_q : vp_res;
    end else if (vp_valid && !skid_q) begin
      skid_res_q <= vp_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_q.status;
  assign win_x_o     = out_q.x;
  assign win_y_o     = out_q.y;
  assign win_z_o     = out_q.z;

`ifndef SYNTHESIS
  a_skid_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_q |-> out_valid_q) else $error("skid holds a result while output is empty");
  a_skid_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_q) |-> $past(out_valid_q && !out_ready_i))
    else $error("skid filled without an output stall");
  a_zero_w_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o) |-> (win_x_o == 0 && win_y_o == 0 && win_z_o == 0))
    else $error("zero w result carries nonzero coordinates");
`endif

endmodule

### tb/ppw_checker.sv
// Checker for the point projection core: predicts window results and compares them.
module ppw_checker import ppw_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         mode_i,
  input  logic [3:0]         element_index_i,
  input  logic signed [31:0] element_value_i,
  input  logic signed [31:0] obj_x_i,
  input  logic signed [31:0] obj_y_i,
  input  logic signed [31:0] obj_z_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [3:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               status_i,
  input  logic signed [31:0] win_x_i,
  input  logic signed [31:0] win_y_i,
  input  logic signed [31:0] win_z_i,
  output int                 err_count_o,
  output int                 pending_o,
  output int                 checked_o,
  output int                 zero_w_o
);

  localparam int FRAC = PPW_FRAC_BITS;
  localparam longint ONE = longint'(1) <<< FRAC;

  logic signed [31:0] eye_m [16];
  logic signed [31:0] proj_m [12];
  logic [15:0] vp_x, vp_y;
  logic [14:0] vp_w, vp_h;
  ppw_res_t expected_q [$];

  function automatic longint clamp32(input longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // product rounded to nearest, ties up
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic longint halve(input longint v);
    return (v + 1) >>> 1;
  endfunction

  function automatic ppw_res_t project_point(input logic signed [31:0] ox,
                                             input logic signed [31:0] oy,
                                             input logic signed [31:0] oz);
    longint obj [3];
    longint eye [4];
    longint clip [3];
    longint ndc [3];
    longint w, t, acc;
    ppw_res_t r;
    obj[0] = ox;
    obj[1] = oy;
    obj[2] = oz;
    for (int i = 0; i < 4; i++) begin
      acc = eye_m[12 + i];
      for (int j = 0; j < 3; j++) acc += fx_mul(eye_m[j * 4 + i], obj[j]);
      eye[i] = clamp32(acc);
    end
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      for (int j = 0; j < 4; j++) acc += fx_mul(proj_m[j * 3 + i], eye[j]);
      clip[i] = clamp32(acc);
    end
    w = -eye[2];
    r = '0;
    if (w == 0) begin
      r.status = 1'b1;
      return r;
    end
    for (int i = 0; i < 3; i++) ndc[i] = clamp32((clip[i] * ONE) / w);
    t = halve((ndc[0] + ONE) * longint'(vp_w));
    acc = clamp32(t + longint'(vp_x) * ONE);
    r.x = acc[31:0];
    t = halve((ndc[1] + ONE) * longint'(vp_h));
    acc = clamp32(t + longint'(vp_y) * ONE);
    r.y = acc[31:0];
    acc = clamp32(halve(ONE + ndc[2]));
    r.z = acc[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    ppw_res_t exp_r;
    if (!rst_ni) begin
      foreach (eye_m[i]) eye_m[i] <= '0;
      foreach (proj_m[i]) proj_m[i] <= '0;
      vp_x <= VP_X_RST;
      vp_y <= VP_Y_RST;
      vp_w <= VP_W_RST;
      vp_h <= VP_H_RST;
      expected_q.delete();
      err_count_o <= 0;
      pending_o <= 0;
      checked_o <= 0;
      zero_w_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result with nothing expected (status %0d x %0d y %0d z %0d)",
                   $time, status_i, win_x_i, win_y_i, win_z_i);
          err_count_o <= err_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          checked_o <= checked_o + 1;
          if (exp_r.status != status_i || exp_r.x != win_x_i || exp_r.y != win_y_i
              || exp_r.z != win_z_i) begin
            err_count_o <= err_count_o + 1;
            if (exp_r.status != status_i)
              $display("%0t: status mismatch, expected %0d, got %0d",
                       $time, exp_r.status, status_i);
            if (exp_r.x != win_x_i)
              $display("%0t: win_x mismatch, expected %0d, got %0d", $time, exp_r.x, win_x_i);
            if (exp_r.y != win_y_i)
              $display("%0t: win_y mismatch, expected %0d, got %0d", $time, exp_r.y, win_y_i);
            if (exp_r.z != win_z_i)
              $display("%0t: win_z mismatch, expected %0d, got %0d", $time, exp_r.z, win_z_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (mode_i)
          MODE_EYE_WR: eye_m[element_index_i] <= element_value_i;
          MODE_PROJ_WR:
            // row 3 of the projection is implied by w = -eye z
            if (element_index_i[1:0] != 2'd3)
              proj_m[element_index_i[3:2] * 3 + element_index_i[1:0]] <= element_value_i;
          MODE_POINT: begin
            exp_r = project_point(obj_x_i, obj_y_i, obj_z_i);
            if (exp_r.status) zero_w_o <= zero_w_o + 1;
            expected_q.insert(expected_q.size(), exp_r);
          end
          default: ;
        endcase
      end
      pending_o <= expected_q.size();
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_VP_X: vp_x <= cfg_data_i;
          CFG_VP_Y: vp_y <= cfg_data_i;
          CFG_VP_W: vp_w <= cfg_data_i[14:0];
          CFG_VP_H: vp_h <= cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

endmodule

### tb/tb_project_point_to_window_core.sv
// Testbench top for the point projection core: stimulus, flow control and verdict.
module tb_project_point_to_window_core;
  import ppw_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam logic [3:0] CFG_UNMAPPED = 4'd4;
  localparam logic [3:0] CFG_TOP_INDEX = 4'hf;
  localparam int DRAIN_WAIT = 80;
  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_TARGET = 1050;
  localparam logic signed [31:0] FX_ONE = 32'sh00010000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] mode_i = '0;
  logic [3:0] element_index_i = '0;
  logic signed [31:0] element_value_i = '0;
  logic signed [31:0] obj_x_i = '0;
  logic signed [31:0] obj_y_i = '0;
  logic signed [31:0] obj_z_i = '0;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [3:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic status_o;
  logic signed [31:0] win_x_o, win_y_o, win_z_o;

  int err_count, pending, checked, zero_w;
  int requests_sent = 0;
  int cfg_settings = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  bit hold_req = 1'b0;
  int rx_style = 0;
  int cycles = 0;

  project_point_to_window_core uut (.*);

  ppw_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .mode_i, .element_index_i,
    .element_value_i, .obj_x_i, .obj_y_i, .obj_z_i, .cfg_valid_i, .cfg_ready_i(cfg_ready_o),
    .cfg_index_i, .cfg_data_i, .out_valid_i(out_valid_o), .out_ready_i, .status_i(status_o),
    .win_x_i(win_x_o), .win_y_i(win_y_o), .win_z_i(win_z_o), .err_count_o(err_count),
    .pending_o(pending), .checked_o(checked), .zero_w_o(zero_w)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout with %0d results outstanding", pending);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise always ready, randomly stalled or periodically stalled
  initial begin
    int phase_cnt;
    phase_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (400) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        phase_cnt++;
        case (rx_style)
          0: out_ready_i <= 1'b1;
          1: out_ready_i <= ($urandom_range(0, 3) != 0);
          default: out_ready_i <= (phase_cnt % 7) < 4;
        endcase
      end
    end
  end

  // leaves valid high; gaps between bursts lower it
  task automatic send(input logic [1:0] m, input logic [3:0] idx, input logic signed [31:0] v,
                      input logic signed [31:0] x, input logic signed [31:0] y,
                      input logic signed [31:0] z);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 20);
      gap = gaps_on ? $urandom_range(0, 6) : 0;
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    mode_i <= m;
    element_index_i <= idx;
    element_value_i <= v;
    obj_x_i <= x;
    obj_y_i <= y;
    obj_z_i <= z;
    do @(posedge clk_i); while (!in_ready_o);
    requests_sent++;
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  task automatic cfg_write(input logic [3:0] idx, input logic [15:0] d);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= d;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_viewport(input logic [15:0] x, input logic [15:0] y,
                              input logic [15:0] w, input logic [15:0] h);
    cfg_write(CFG_VP_X, x);
    cfg_write(CFG_VP_Y, y);
    cfg_write(CFG_VP_W, w);
    cfg_write(CFG_VP_H, h);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    cfg_settings++;
  endtask

  function automatic logic signed [31:0] rnd_fx();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom_range(0, 32'h80000) - 32'h40000;
    endcase
  endfunction

  task automatic load_matrices(input bit flat_w);
    int n;
    n = $urandom_range(4, 16);
    repeat (n) send(MODE_EYE_WR, 4'($urandom_range(0, 15)), rnd_fx(), '0, '0, '0);
    // keep eye z alive most of the time, or kill it entirely
    send(MODE_EYE_WR, 4'd10, flat_w ? 32'sd0 : rnd_fx() | 32'sd1, '0, '0, '0);
    if (flat_w) begin
      send(MODE_EYE_WR, 4'd2, '0, '0, '0, '0);
      send(MODE_EYE_WR, 4'd6, '0, '0, '0, '0);
      send(MODE_EYE_WR, 4'd14, '0, '0, '0, '0);
    end
    n = $urandom_range(3, 16);
    repeat (n) send(MODE_PROJ_WR, 4'($urandom_range(0, 15)), rnd_fx(), '0, '0, '0);
  endtask

  task automatic random_phase(input int n_items);
    int stop_at;
    stop_at = requests_sent + n_items;
    while (requests_sent < stop_at) begin
      load_matrices($urandom_range(0, 11) == 0);
      repeat ($urandom_range(5, 30)) begin
        if ($urandom_range(0, 19) == 0)
          send($urandom_range(0, 1) ? MODE_UNUSED : MODE_PROJ_WR, 4'($urandom_range(0, 15)) | 4'd3,
               $urandom, $urandom, $urandom, $urandom);
        else
          send(MODE_POINT, 4'($urandom), $urandom, rnd_fx(), rnd_fx(), rnd_fx());
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: unit modelview pushed back 5 along z, unit-ish projection
    rx_style = 0;
    gaps_on = 1'b0;
    send(MODE_EYE_WR, 4'd0, FX_ONE, '0, '0, '0);
    send(MODE_EYE_WR, 4'd5, FX_ONE, '0, '0, '0);
    send(MODE_EYE_WR, 4'd10, FX_ONE, '0, '0, '0);
    send(MODE_EYE_WR, 4'd14, -5 * FX_ONE, '0, '0, '0);
    send(MODE_PROJ_WR, 4'd0, FX_ONE, '0, '0, '0);
    send(MODE_PROJ_WR, 4'd5, FX_ONE, '0, '0, '0);
    send(MODE_PROJ_WR, 4'd10, FX_ONE, '0, '0, '0);
    send(MODE_PROJ_WR, 4'd15, 32'sh7fffffff, '0, '0, '0);   // row 3, dropped
    send(MODE_UNUSED, 4'hf, 32'sh80000000, 32'shffffffff, 32'shffffffff, 32'shffffffff);
    send(MODE_POINT, '0, '0, '0, '0, '0);
    send(MODE_POINT, '0, '0, FX_ONE, -FX_ONE, 5 * FX_ONE);  // eye z = 0
    send(MODE_POINT, '0, '0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send(MODE_POINT, '0, '0, 32'sh80000000, 32'sh80000000, 32'sh80000000);
    send(MODE_POINT, '0, '0, 2 * FX_ONE, -3 * FX_ONE, 32'sh00008000);
    send(MODE_EYE_WR, 4'd3, 32'sh7fffffff, '0, '0, '0);
    send(MODE_PROJ_WR, 4'd14, 32'sh80000000, '0, '0, '0);
    send(MODE_POINT, '0, '0, 32'sh7fffffff, 32'sh80000000, -FX_ONE);
    send(MODE_POINT, '0, '0, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff);
    go_idle();

    set_viewport(16'd0, 16'd0, 16'd0, 16'd0);
    send(MODE_POINT, '0, '0, FX_ONE, FX_ONE, -FX_ONE);
    go_idle();
    set_viewport(16'hffff, 16'hffff, 16'd16384, 16'd16384);
    cfg_write(CFG_UNMAPPED, 16'hffff);
    cfg_write(CFG_TOP_INDEX, 16'h0000);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    send(MODE_POINT, '0, '0, 32'sh7fffffff, -FX_ONE, FX_ONE);
    send(MODE_POINT, '0, '0, FX_ONE, FX_ONE, 32'sh80000000);

    // random phases, each under its own viewport and flow-control style
    for (int ph = 0; ph < 6; ph++) begin
      go_idle();
      case (ph)
        0: set_viewport(16'd0, 16'd0, 16'd640, 16'd480);
        1: set_viewport(16'hffff, 16'h0000, 16'hffff, 16'h7fff);  // widths keep 15 bits
        2: set_viewport(16'($urandom), 16'($urandom), 16'($urandom_range(0, 16384)),
                        16'($urandom_range(0, 16384)));
        default: set_viewport(16'($urandom_range(0, 2048)), 16'($urandom_range(0, 2048)),
                              16'($urandom_range(1, 4096)), 16'($urandom_range(1, 4096)));
      endcase
      rx_style = ph % 3;
      gaps_on = (ph != 3);
      if (ph == 2) begin
        // stall the output long enough to back the pipeline up
        hold_req = 1'b1;
        gaps_on = 1'b0;
        repeat (120) send(MODE_POINT, '0, '0, rnd_fx(), rnd_fx(), rnd_fx());
        gaps_on = 1'b1;
      end
      random_phase(80);
      if (ph == 4) begin
        in_valid_i <= 1'b0;
        burst_left = 0;
        @(posedge clk_i);
        wait (pending == 0);
        @(posedge clk_i);
      end
      random_phase((ITEM_TARGET - requests_sent) / (6 - ph) - 80);
    end

    in_valid_i <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    $display("Sent %0d requests over %0d viewport settings; %0d window results checked,",
             requests_sent, cfg_settings, checked);
    $display("%0d of them with zero clip w, plus long output stalls and full drains.", zero_w);
    if (err_count == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### project_point_to_window_core.f
sv/ppw_pkg.sv
sv/ppw_xform.sv
sv/ppw_div.sv
sv/ppw_vp.sv
sv/project_point_to_window_core.sv
tb/ppw_checker.sv
tb/tb_project_point_to_window_core.sv
